[hw/rtl/dcfe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfe_pkg: shared constants and types for the duty command frame encoder
// Frame bytes, opcodes, CRC polynomial, register indexes and control structs.
// ----------------------------------------------------------------------------
package dcfe_pkg;

  localparam int MAX_SLAVES_DEF = 4;
  localparam int NUM_IDS        = 4;
  localparam int ID_SEL_W       = 2;

  localparam int DUTY_W = 18;
  localparam int BYTE_W = 8;
  localparam int CRC_W  = 16;
  localparam int POS_W  = 4;
  localparam int SR_W   = 56;

  localparam logic signed [DUTY_W-1:0] DUTY_MAX = 18'sd95000;
  localparam logic signed [DUTY_W-1:0] DUTY_MIN = -18'sd95000;

  localparam logic [BYTE_W-1:0] OP_SET_DUTY = 8'd5;
  localparam logic [BYTE_W-1:0] OP_FORWARD  = 8'd34;
  localparam logic [BYTE_W-1:0] FRAME_START = 8'd2;
  localparam logic [BYTE_W-1:0] FRAME_STOP  = 8'd3;
  localparam logic [CRC_W-1:0]  CRC_POLY    = 16'h1021;

  // payload lengths and fixed byte positions inside a frame
  localparam logic [POS_W-1:0] LEN_LOCAL = 4'd5;
  localparam logic [POS_W-1:0] LEN_FWD   = 4'd7;
  localparam logic [POS_W-1:0] POS_START = 4'd0;
  localparam logic [POS_W-1:0] POS_LEN   = 4'd1;

  // configuration register indexes
  localparam logic [2:0] CFG_SLAVE_COUNT = 3'd0;
  localparam logic [2:0] CFG_SLAVE_ID_A  = 3'd1;
  localparam logic [2:0] CFG_SLAVE_ID_B  = 3'd2;
  localparam logic [2:0] CFG_SLAVE_ID_C  = 3'd3;
  localparam logic [2:0] CFG_SLAVE_ID_D  = 3'd4;

  typedef struct packed {
    logic clear;
    logic advance;
  } crc_ctrl_t;

endpackage

[hw/rtl/dcfe_crc16.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfe_crc16: running CRC-16, one byte per cycle while advance is set
// Polynomial 0x1021, zero seed, MSB first, no reflection, no final xor.
// ----------------------------------------------------------------------------
module dcfe_crc16 (
  input  logic                         clk,
  input  dcfe_pkg::crc_ctrl_t          ctrl,
  input  logic [dcfe_pkg::BYTE_W-1:0]  data_byte,
  output logic [dcfe_pkg::CRC_W-1:0]   crc
);

  logic [dcfe_pkg::CRC_W-1:0] crc_next;

  always_comb begin
    logic [dcfe_pkg::CRC_W-1:0] c;
    c = crc ^ {data_byte, 8'h00};
    for (int k = 0; k < dcfe_pkg::BYTE_W; k++) begin
      if (c[dcfe_pkg::CRC_W-1]) begin
        c = {c[dcfe_pkg::CRC_W-2:0], 1'b0} ^ dcfe_pkg::CRC_POLY;
      end else begin
        c = {c[dcfe_pkg::CRC_W-2:0], 1'b0};
      end
    end
    crc_next = c;
  end

  // no reset: cleared at the start byte of every frame
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      crc <= '0;
    end else if (ctrl.advance) begin
      crc <= crc_next;
    end
  end

endmodule

[hw/rtl/duty_command_frame_encoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duty_command_frame_encoder_unit: duty command to framed byte stream
// Clamps a duty command and emits a local set-duty frame plus one forward
// frame per configured slave, one byte word per cycle while the sink is ready, with a running CRC.
// ----------------------------------------------------------------------------
// Start: an accepted command sets busy, then the sequencer loads the first word into the output register.
// Throughput: 10 + 12*n words per command (n = effective slave count, 0..4),
//   one word per cycle while the sink is ready, set by the byte sequencer.
//   s_axis_tready is low while a command is in progress, so a new command
//   is taken only once the sequencer has issued the last word.
// Reset: synchronous; slave_count = 1, slave_id_a = 10, other ids 0.
// ----------------------------------------------------------------------------
module duty_command_frame_encoder_unit #(
  parameter int MAX_SLAVES = dcfe_pkg::MAX_SLAVES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // command in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [17:0] duty (signed), [23:18] zero
  // byte stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] tx_byte
  output logic        m_axis_tuser,   // [0] frame_end
  output logic        m_axis_tlast,   // last word of this command
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int FIDX_W = $clog2(MAX_SLAVES + 1);
  localparam int POS_W  = dcfe_pkg::POS_W;
  localparam int BYTE_W = dcfe_pkg::BYTE_W;
  localparam int SR_W   = dcfe_pkg::SR_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [2:0]        slave_count;
  logic [BYTE_W-1:0] slave_id [dcfe_pkg::NUM_IDS];

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_count <= 3'd1;
      slave_id[0] <= 8'd10;
      slave_id[1] <= 8'd0;
      slave_id[2] <= 8'd0;
      slave_id[3] <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dcfe_pkg::CFG_SLAVE_COUNT: slave_count <= cfg_data[2:0];
        dcfe_pkg::CFG_SLAVE_ID_A:  slave_id[0] <= cfg_data;
        dcfe_pkg::CFG_SLAVE_ID_B:  slave_id[1] <= cfg_data;
        dcfe_pkg::CFG_SLAVE_ID_C:  slave_id[2] <= cfg_data;
        dcfe_pkg::CFG_SLAVE_ID_D:  slave_id[3] <= cfg_data;
        default: ; // unknown index, ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Command capture and clamp
  // --------------------------------------------------------------------------
  logic                                busy;
  logic                                s_fire;
  logic signed [dcfe_pkg::DUTY_W-1:0]  duty_in;
  logic signed [dcfe_pkg::DUTY_W-1:0]  duty_clamped;
  logic signed [dcfe_pkg::DUTY_W-1:0]  duty_q;
  logic [FIDX_W-1:0]                   cnt_eff;
  logic [FIDX_W-1:0]                   cnt;

  assign s_axis_tready = !busy;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign duty_in       = signed'(s_axis_tdata[dcfe_pkg::DUTY_W-1:0]);

  always_comb begin
    priority if (duty_in > dcfe_pkg::DUTY_MAX) begin
      duty_clamped = dcfe_pkg::DUTY_MAX;
    end else if (duty_in < dcfe_pkg::DUTY_MIN) begin
      duty_clamped = dcfe_pkg::DUTY_MIN;
    end else begin
      duty_clamped = duty_in;
    end
  end

  // slave counts beyond the build limit saturate
  assign cnt_eff = (int'(slave_count) > MAX_SLAVES) ? FIDX_W'(MAX_SLAVES)
                                                    : FIDX_W'(slave_count);

  // --------------------------------------------------------------------------
  // Byte sequencer: frame index, byte position, payload shift register
  // --------------------------------------------------------------------------
  logic [FIDX_W-1:0]            fidx;     // 0 = local frame, k = slave k
  logic [POS_W-1:0]             pos;      // byte position within frame
  logic [SR_W-1:0]              pl_sr;    // payload, MSB byte goes out first
  logic [SR_W-1:0]              pl_load;
  logic [POS_W-1:0]             frame_len;
  logic [dcfe_pkg::ID_SEL_W-1:0] id_sel;
  logic [31:0]                  duty_word;
  logic [BYTE_W-1:0]            cur_byte;
  logic                         cur_end;
  logic                         cur_last;
  logic                         cur_payload;
  logic                         step;
  logic [dcfe_pkg::CRC_W-1:0]   crc;
  dcfe_pkg::crc_ctrl_t          crc_ctrl;

  logic                         out_valid;
  logic [BYTE_W-1:0]            out_byte;
  logic                         out_end;
  logic                         out_last;

  assign step      = busy && (!out_valid || m_axis_tready);
  assign frame_len = (fidx == '0) ? dcfe_pkg::LEN_LOCAL : dcfe_pkg::LEN_FWD;
  assign id_sel    = dcfe_pkg::ID_SEL_W'(fidx - FIDX_W'(1));
  assign duty_word = {{(32 - dcfe_pkg::DUTY_W){duty_q[dcfe_pkg::DUTY_W-1]}}, duty_q};

  assign pl_load = (fidx == '0)
                   ? {dcfe_pkg::OP_SET_DUTY, duty_word, 16'h0000}
                   : {dcfe_pkg::OP_FORWARD, slave_id[id_sel], dcfe_pkg::OP_SET_DUTY,
                      duty_word};

  // start, length, payload, crc high, crc low, stop
  always_comb begin
    cur_byte    = pl_sr[SR_W-1 -: BYTE_W];
    cur_end     = 1'b0;
    cur_payload = 1'b0;
    priority if (pos == dcfe_pkg::POS_START) begin
      cur_byte = dcfe_pkg::FRAME_START;
    end else if (pos == dcfe_pkg::POS_LEN) begin
      cur_byte = BYTE_W'(frame_len);
    end else if (pos <= POS_W'(frame_len + 4'd1)) begin
      cur_payload = 1'b1;
    end else if (pos == POS_W'(frame_len + 4'd2)) begin
      cur_byte = crc[15:8];
    end else if (pos == POS_W'(frame_len + 4'd3)) begin
      cur_byte = crc[7:0];
    end else begin
      cur_byte = dcfe_pkg::FRAME_STOP;
      cur_end  = 1'b1;
    end
  end

  assign cur_last = cur_end && (fidx == cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fidx <= '0;
      pos  <= '0;
      cnt  <= '0;
    end else if (s_fire) begin
      busy <= 1'b1;
      fidx <= '0;
      pos  <= '0;
      cnt  <= cnt_eff;
    end else if (step) begin
      if (cur_end) begin
        pos <= '0;
        if (cur_last) begin
          busy <= 1'b0;
        end else begin
          fidx <= fidx + FIDX_W'(1);
        end
      end else begin
        pos <= pos + POS_W'(1);
      end
    end
  end

  // payload path, no reset needed
  always_ff @(posedge clk) begin
    if (s_fire) begin
      duty_q <= duty_clamped;
    end
    if (step && pos == dcfe_pkg::POS_START) begin
      pl_sr <= pl_load;
    end else if (step && cur_payload) begin
      pl_sr <= {pl_sr[SR_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
    end
  end

  assign crc_ctrl.clear   = step && (pos == dcfe_pkg::POS_START);
  assign crc_ctrl.advance = step && cur_payload;

  dcfe_crc16 u_crc (
    .clk       (clk),
    .ctrl      (crc_ctrl),
    .data_byte (cur_byte),
    .crc       (crc)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte <= cur_byte;
      out_end  <= cur_end;
      out_last <= cur_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_byte;
  assign m_axis_tuser  = out_end;
  assign m_axis_tlast  = out_last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_last_on_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_end)
    else $error("last word is not a stop byte");

  a_fidx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> fidx <= cnt)
    else $error("frame index beyond slave count");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> pos <= POS_W'(frame_len + 4'd4))
    else $error("byte position beyond frame end");

  a_done: assert property (@(posedge clk) disable iff (rst)
    step && cur_last |=> !busy && out_valid && out_last)
    else $error("sequencer did not finish on last word");

endmodule
